// ===== rtl/compare_pulse_generator_macros.svh =====
// Assertion helpers for the compare pulse generator.
// Every check is clocked on clk and stays quiet while rst is high.
`ifndef COMPARE_PULSE_GENERATOR_MACROS_SVH
`define COMPARE_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication
`define CPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cpg_pkg.sv =====
`timescale 1ns / 1ps
package cpg_pkg;

  // Counter width used when the top level is not overridden
  localparam int COUNTER_BITS_DEFAULT = 16;

  // Configuration register layout
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_POLARITY = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_LIMIT      = 2'd2;

  // Register reset values
  localparam logic                     CHANNEL_ENABLE_RST  = 1'b1;
  localparam logic                     INVERT_POLARITY_RST = 1'b1;
  localparam logic [CFG_DATA_BITS-1:0] NEAR_LIMIT_RST      = 16'd500;

  // Scheduling constants in counter ticks
  localparam int RESTART_DELAY = 250;
  localparam int CLAMP_AHEAD   = 2;

  // Function codes carried on the input user field
  typedef enum logic [1:0] {
    FUNC_EVENT   = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  // Configuration as seen by the scheduler
  typedef struct packed {
    logic                     channel_enable;
    logic                     invert_polarity;
    logic [CFG_DATA_BITS-1:0] near_limit;
  } cfg_t;

  // Single-bit result fields, packed as they sit above compare_time
  typedef struct packed {
    logic cycle_started;
    logic pin_timer_owned;
    logic next_action;
  } res_flags_t;

endpackage

// ===== rtl/compare_pulse_generator.sv =====
`timescale 1ns / 1ps
// Output-compare pulse scheduler for one timer channel.
// Input stream: one beat per request. s_tuser carries the function code (compare
// event, read-and-clear of the cycle flag, restart); s_tdata carries the current
// counter value and the staged on-time and period.
// Output stream: one beat per request with the next compare time, the level to
// drive there, pin ownership and the cycle flag.
// Config channel: register writes by index, always ready; write only while idle.
// A request accepted into the input register passes the scheduler into the result
// register, which drives m_tvalid. One request per cycle is sustained while the
// receiver takes results: the input register feeds the scheduler state update and
// the result register together, so the next request sees the updated state.
// Reset clears both stream registers and sets the scheduler to its idle state
// (pin released, off phase, period all ones) and the registers to their defaults.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and s_tready drops until the result is taken.
`include "compare_pulse_generator_macros.svh"
module compare_pulse_generator
  import cpg_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // counter_now, new_on_time, new_period
  input  logic [((3*COUNTER_BITS+7)/8)*8-1:0]      s_tdata,
  // func
  input  logic [1:0]                               s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // compare_time, next_action, pin_timer_owned, cycle_started
  output logic [((COUNTER_BITS+3+7)/8)*8-1:0]      m_tdata,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]                cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                 cfg_data
);

  localparam int C      = COUNTER_BITS;
  localparam int OUT_W  = ((C + 3 + 7) / 8) * 8;
  localparam int RES_W  = C + 3;

  cfg_t                cfg;
  logic                in_valid;
  func_t               in_func;
  logic [3*C-1:0]      in_data;
  logic                fire;
  logic                can_load;
  logic [C-1:0]        compare_time;
  res_flags_t          flags;
  logic [RES_W-1:0]    result;

  assign cfg_ready = 1'b1;

  cpg_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register: refill when empty or when its beat moves on
  assign fire     = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= func_t'(s_tuser);
      in_data <= s_tdata[3*C-1:0];
    end
  end

  cpg_sched #(
    .COUNTER_BITS (C)
  ) u_sched (
    .clk          (clk),
    .rst          (rst),
    .step_en      (fire),
    .func         (in_func),
    .counter_now  (in_data[C-1:0]),
    .new_on_time  (in_data[2*C-1:C]),
    .new_period   (in_data[3*C-1:2*C]),
    .cfg          (cfg),
    .compare_time (compare_time),
    .flags        (flags)
  );

  assign result = {flags, compare_time};

  cpg_out_reg #(
    .WIDTH (OUT_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .data     (OUT_W'(result)),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks
  `CPG_ASSERT_NEXT(a_in_hold, in_valid && !fire, in_valid && $stable(in_data), "input beat lost while stalled")
  `CPG_ASSERT_NEXT(a_fire_loads, fire, m_tvalid, "processed beat did not reach the output")
  `CPG_ASSERT_NEXT(a_disabled_release, fire && (in_func == FUNC_EVENT) && !cfg.channel_enable, !m_tdata[C+1], "disabled event kept the pin")
  `CPG_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config channel not ready")

endmodule

// ===== rtl/cpg_cfg.sv =====
`timescale 1ns / 1ps
module cpg_cfg
  import cpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output cfg_t                      cfg
);

  // Hold the configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable  <= CHANNEL_ENABLE_RST;
      cfg.invert_polarity <= INVERT_POLARITY_RST;
      cfg.near_limit      <= NEAR_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHANNEL_ENABLE:  cfg.channel_enable  <= wr_data[0];
        REG_INVERT_POLARITY: cfg.invert_polarity <= wr_data[0];
        REG_NEAR_LIMIT:      cfg.near_limit      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cpg_sched.sv =====
`timescale 1ns / 1ps
module cpg_sched
  import cpg_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step_en,
  input  func_t                   func,
  input  logic [COUNTER_BITS-1:0] counter_now,
  input  logic [COUNTER_BITS-1:0] new_on_time,
  input  logic [COUNTER_BITS-1:0] new_period,
  input  cfg_t                    cfg,
  output logic [COUNTER_BITS-1:0] compare_time,
  output res_flags_t              flags
);

  localparam int CMP_W = (COUNTER_BITS > CFG_DATA_BITS) ? COUNTER_BITS : CFG_DATA_BITS;

  // Scheduler state
  logic [COUNTER_BITS-1:0] next_compare, next_compare_next;
  logic [COUNTER_BITS-1:0] active_on_time, active_on_time_next;
  logic [COUNTER_BITS-1:0] active_period, active_period_next;
  logic                    off_phase, off_phase_next;
  logic                    cycle_flag, cycle_flag_next;
  logic                    pin_owned, pin_owned_next;
  logic                    level_code, level_code_next;
  logic                    flag_out;

  // Step datapath
  logic [COUNTER_BITS-1:0] step;
  logic [COUNTER_BITS-1:0] target;
  logic [COUNTER_BITS-1:0] soon;
  logic [COUNTER_BITS-1:0] ahead;
  logic                    high;
  logic                    near;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_compare   <= '0;
      active_on_time <= '0;
      active_period  <= '1;
      off_phase      <= 1'b1;
      cycle_flag     <= 1'b0;
      pin_owned      <= 1'b0;
      level_code     <= 1'b0;
    end else if (step_en) begin
      next_compare   <= next_compare_next;
      active_on_time <= active_on_time_next;
      active_period  <= active_period_next;
      off_phase      <= off_phase_next;
      cycle_flag     <= cycle_flag_next;
      pin_owned      <= pin_owned_next;
      level_code     <= level_code_next;
    end
  end

  // Pick the step for the coming phase and its edge level
  always_comb begin
    if (off_phase) begin
      if (active_on_time == '0 || active_on_time >= active_period) begin
        step = active_period - (active_period >> 1);
      end else begin
        step = active_period - active_on_time;
      end
      high = (new_on_time != '0);
    end else begin
      step = new_on_time;
      high = 1'b0;
      if (new_on_time == '0) begin
        step = new_period >> 1;
      end else if (new_on_time >= new_period) begin
        high = 1'b1;
        step = new_period >> 1;
      end
    end
    target = next_compare + step;
    soon   = counter_now + COUNTER_BITS'(CLAMP_AHEAD);
    ahead  = target - soon;
    near   = CMP_W'(step) < CMP_W'(cfg.near_limit);
  end

  // Apply the function to the state
  always_comb begin
    next_compare_next   = next_compare;
    active_on_time_next = active_on_time;
    active_period_next  = active_period;
    off_phase_next      = off_phase;
    cycle_flag_next     = cycle_flag;
    pin_owned_next      = pin_owned;
    level_code_next     = level_code;
    flag_out            = cycle_flag;
    unique case (func)
      FUNC_EVENT: begin
        if (!cfg.channel_enable) begin
          // release the pin and coast one period
          pin_owned_next    = 1'b0;
          next_compare_next = next_compare + active_period;
          off_phase_next    = 1'b1;
          cycle_flag_next   = 1'b0;
        end else begin
          pin_owned_next      = 1'b1;
          active_on_time_next = new_on_time;
          active_period_next  = new_period;
          if (!off_phase) begin
            cycle_flag_next = 1'b1;
          end
          // clamp a short step that already lies in the past
          if (near && ahead[COUNTER_BITS-1]) begin
            next_compare_next = soon;
          end else begin
            next_compare_next = target;
          end
          level_code_next = high ^ !cfg.invert_polarity;
          off_phase_next  = !off_phase;
        end
        flag_out = cycle_flag_next;
      end
      FUNC_CLEAR: begin
        cycle_flag_next = 1'b0;
      end
      FUNC_RESTART: begin
        next_compare_next = counter_now + COUNTER_BITS'(RESTART_DELAY);
        off_phase_next    = 1'b0;
        level_code_next   = cfg.invert_polarity;
      end
      default: ;
    endcase
  end

  assign compare_time          = next_compare_next;
  assign flags.next_action     = level_code_next;
  assign flags.pin_timer_owned = pin_owned_next;
  assign flags.cycle_started   = flag_out;

endmodule

// ===== rtl/cpg_out_reg.sv =====
`timescale 1ns / 1ps
module cpg_out_reg #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [WIDTH-1:0] data,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [WIDTH-1:0] m_tdata
);

  // Take a new beat whenever the slot is empty or drains this cycle
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      m_tdata <= data;
    end
  end

endmodule

// ===== tb/sv/compare_pulse_generator_test.sv =====
`timescale 1ns / 1ps
module compare_pulse_generator_test;
  import cpg_pkg::*;

  localparam int CW = COUNTER_BITS_DEFAULT;
  localparam int S_W = ((3 * CW + 7) / 8) * 8;
  localparam int M_W = ((CW + 3 + 7) / 8) * 8;
  localparam int ITEM_GOAL = 950;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_IDLE = 16;
  // Function code outside the defined set; the block must leave its state alone
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    bit [CW-1:0] compare_time;
    bit          next_action;
    bit          pin_timer_owned;
    bit          cycle_started;
  } schedule_t;

  // Tracks the channel schedule and holds the results still owed by the block
  class compare_schedule_board;
    bit          enable;
    bit          invert;
    bit [CW-1:0] near_limit;
    bit [CW-1:0] next_cmp;
    bit [CW-1:0] on_time;
    bit [CW-1:0] period;
    bit          off_phase;
    bit          cycle_flag;
    bit          pin_owned;
    bit          level;
    schedule_t   owed_schedule[$];
    int          failures;

    function new();
      enable     = CHANNEL_ENABLE_RST;
      invert     = INVERT_POLARITY_RST;
      near_limit = NEAR_LIMIT_RST;
      next_cmp   = '0;
      on_time    = '0;
      period     = '1;
      off_phase  = 1'b1;
      cycle_flag = 1'b0;
      pin_owned  = 1'b0;
      level      = 1'b0;
      failures   = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] index, bit [CFG_DATA_BITS-1:0] value);
      case (index)
        REG_CHANNEL_ENABLE: enable = value[0];
        REG_INVERT_POLARITY: invert = value[0];
        REG_NEAR_LIMIT: near_limit = value[CW-1:0];
        default: ;
      endcase
    endfunction

    // Schedule the next edge for one compare event
    function void advance_compare(bit [CW-1:0] now, bit [CW-1:0] on_in, bit [CW-1:0] per_in);
      bit [CW-1:0] step;
      bit [CW-1:0] target;
      bit [CW-1:0] soon;
      bit [CW-1:0] gap;
      bit          high;
      high = 1'b0;
      if (!enable) begin
        pin_owned  = 1'b0;
        next_cmp   = next_cmp + period;
        off_phase  = 1'b1;
        cycle_flag = 1'b0;
        return;
      end
      pin_owned = 1'b1;
      if (off_phase) begin
        // Finish the period with the old timing, then latch the staged one
        if (on_time == 0 || on_time >= period)
          step = period - (period >> 1);
        else
          step = period - on_time;
        on_time = on_in;
        period  = per_in;
        high    = (on_time != 0);
      end else begin
        cycle_flag = 1'b1;
        on_time    = on_in;
        period     = per_in;
        step       = on_time;
        if (on_time == 0) begin
          step = period >> 1;
        end else if (on_time >= period) begin
          high = 1'b1;
          step = period >> 1;
        end
      end
      target = next_cmp + step;
      // Short steps that land behind the counter move up to just ahead of it
      if (step < near_limit) begin
        soon = now + CW'(CLAMP_AHEAD);
        gap  = target - soon;
        if (gap[CW-1])
          target = soon;
      end
      next_cmp = target;
      if (!invert)
        high = !high;
      level     = high;
      off_phase = !off_phase;
    endfunction

    function void note_request(logic [1:0] func, bit [CW-1:0] now, bit [CW-1:0] on_in,
                               bit [CW-1:0] per_in);
      schedule_t owed;
      bit        flag_seen;
      flag_seen = cycle_flag;
      case (func)
        FUNC_EVENT: begin
          advance_compare(now, on_in, per_in);
          flag_seen = cycle_flag;
        end
        FUNC_CLEAR: cycle_flag = 1'b0;
        FUNC_RESTART: begin
          next_cmp  = now + CW'(RESTART_DELAY);
          off_phase = 1'b0;
          level     = invert;
        end
        default: ;
      endcase
      owed.compare_time    = next_cmp;
      owed.next_action     = level;
      owed.pin_timer_owned = pin_owned;
      owed.cycle_started   = flag_seen;
      owed_schedule.push_back(owed);
    endfunction

    function void check_result(logic [M_W-1:0] beat);
      schedule_t owed;
      if (owed_schedule.size() == 0) begin
        $error("unexpected result beat 0x%0h", beat);
        failures++;
        return;
      end
      owed = owed_schedule.pop_front();
      if (beat[CW-1:0] !== owed.compare_time) begin
        $error("compare_time: expected %0d, actual %0d", owed.compare_time, beat[CW-1:0]);
        failures++;
      end
      if (beat[CW] !== owed.next_action) begin
        $error("next_action: expected %0d, actual %0d", owed.next_action, beat[CW]);
        failures++;
      end
      if (beat[CW+1] !== owed.pin_timer_owned) begin
        $error("pin_timer_owned: expected %0d, actual %0d", owed.pin_timer_owned, beat[CW+1]);
        failures++;
      end
      if (beat[CW+2] !== owed.cycle_started) begin
        $error("cycle_started: expected %0d, actual %0d", owed.cycle_started, beat[CW+2]);
        failures++;
      end
    endfunction

    function int pending();
      return owed_schedule.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  // counter_now, new_on_time, new_period
  logic [S_W-1:0]            s_tdata;
  // func
  logic [1:0]                s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // compare_time, next_action, pin_timer_owned, cycle_started
  logic [M_W-1:0]            m_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  compare_schedule_board sb = new();
  bit tx_burst;
  bit rx_burst;

  compare_pulse_generator uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one request after a random gap (none in a burst) and hold it until accepted
  task automatic send_request(logic [1:0] func, bit [CW-1:0] now, bit [CW-1:0] on_in,
                              bit [CW-1:0] per_in);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= S_W'({per_in, on_in, now});
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, now, on_in, per_in);
  endtask

  // Drop the request stream and wait for every owed result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; the block must be idle
  task automatic write_registers(bit en, bit inv, bit [CFG_DATA_BITS-1:0] near);
    logic [CFG_INDEX_BITS-1:0] idx[3];
    bit [CFG_DATA_BITS-1:0]    val[3];
    idx = '{REG_CHANNEL_ENABLE, REG_INVERT_POLARITY, REG_NEAR_LIMIT};
    val = '{CFG_DATA_BITS'(en), CFG_DATA_BITS'(inv), near};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Build one request, mostly timer-interrupt shaped around the pending compare
  task automatic random_request();
    int          pick;
    logic [1:0]  func;
    bit [CW-1:0] now;
    bit [CW-1:0] on_in;
    bit [CW-1:0] per_in;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      func   = 2'($urandom_range(0, 3));
      now    = CW'($urandom);
      on_in  = CW'($urandom);
      per_in = CW'($urandom);
    end else begin
      if (pick < 80)
        func = FUNC_EVENT;
      else if (pick < 88)
        func = FUNC_CLEAR;
      else if (pick < 96)
        func = FUNC_RESTART;
      else
        func = FUNC_UNUSED;
      // Counter a little early, late enough to force a clamp, or anywhere
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: now = sb.next_cmp - CW'($urandom_range(0, 50));
        5, 6, 7: now = sb.next_cmp + CW'($urandom_range(0, 800));
        default: now = CW'($urandom);
      endcase
      per_in = ($urandom_range(0, 4) == 0) ? CW'($urandom) : CW'($urandom_range(0, 1200));
      case ($urandom_range(0, 7))
        0: on_in = '0;
        1: on_in = per_in + CW'($urandom_range(0, 3));
        2: on_in = CW'($urandom);
        default: on_in = CW'($urandom_range(0, per_in));
      endcase
    end
    send_request(func, now, on_in, per_in);
  endtask

  // Result side: random stall per beat (none in a burst), check every accepted beat
  initial begin : receiver
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  // End the run when no beat moves anywhere for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("compare_pulse_generator_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int          items_left;
    int          phase_len;
    bit          en;
    bit [CW-1:0] near;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    tx_burst  = 1'b0;
    rx_burst  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unused code, flag clear, period start from reset state,
    // field extremes, restart across the wrap, clamp, flag read-and-clear,
    // zero on-time and on-time at least the period
    send_request(FUNC_UNUSED, '0, '0, '0);
    send_request(FUNC_CLEAR, '1, '1, '1);
    send_request(FUNC_EVENT, '0, '0, '0);
    send_request(FUNC_EVENT, '1, '1, '1);
    send_request(FUNC_RESTART, '1, '0, '0);
    send_request(FUNC_EVENT, 16'd65530, 16'd100, 16'd400);
    send_request(FUNC_EVENT, 16'd700, 16'd100, 16'd400);
    send_request(FUNC_CLEAR, 16'd710, '0, '0);
    send_request(FUNC_CLEAR, 16'd720, '0, '0);
    send_request(FUNC_EVENT, 16'd702, 16'd0, 16'd600);
    send_request(FUNC_EVENT, 16'd1000, 16'd300, 16'd300);
    send_request(FUNC_EVENT, 16'd1300, 16'd5, 16'd10);
    drain_results();

    // Disabled channel, inverted level, zero near limit
    write_registers(1'b0, 1'b0, '0);
    send_request(FUNC_EVENT, 16'd2000, 16'd50, 16'd100);
    send_request(FUNC_EVENT, 16'd2100, 16'd50, 16'd100);
    send_request(FUNC_RESTART, 16'd40000, '0, '0);
    send_request(FUNC_CLEAR, 16'd40010, '0, '0);
    send_request(FUNC_EVENT, 16'd40020, 16'd7, 16'd9);
    drain_results();

    // Enabled, inverted level, widest near limit
    write_registers(1'b1, 1'b0, '1);
    send_request(FUNC_RESTART, 16'd100, '0, '0);
    send_request(FUNC_EVENT, 16'd350, 16'd200, 16'd1000);
    send_request(FUNC_EVENT, 16'd60000, 16'd200, 16'd1000);
    send_request(FUNC_EVENT, '1, '1, '0);
    send_request(FUNC_UNUSED, 16'd12345, 16'd1, 16'd2);
    drain_results();

    // Random phases, each under its own register settings
    items_left = ITEM_GOAL;
    while (items_left > 0) begin
      phase_len = $urandom_range(40, 120);
      if (phase_len > items_left)
        phase_len = items_left;
      en = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 5))
        0: near = '0;
        1: near = '1;
        2: near = CW'(NEAR_LIMIT_RST);
        3: near = CW'($urandom);
        default: near = CW'($urandom_range(0, 2000));
      endcase
      write_registers(en, 1'($urandom_range(0, 1)), near);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      // Most phases open with a restart, like a channel being armed
      if ($urandom_range(0, 3) != 0) begin
        send_request(FUNC_RESTART, CW'($urandom), CW'($urandom), CW'($urandom));
        phase_len--;
        items_left--;
      end
      repeat (phase_len) random_request();
      items_left -= phase_len;
      drain_results();
    end

    // Let any stray beat show up before the verdict
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("compare_pulse_generator_test: PASS");
    else
      $display("compare_pulse_generator_test: FAIL");
    $finish;
  end

endmodule
